/* design/bfa_pkg.sv */
// ----------------------------------------------------------------------------
// bfa_pkg: shared types and constants of the binned free-list allocator
// Field widths, status and command codes, state machine types, defaults.
// ----------------------------------------------------------------------------
package bfa_pkg;

   // Default geometry of the pool
   localparam int unsigned NUM_BINS_DEFAULT      = 8;
   localparam int unsigned SLOTS_PER_BIN_DEFAULT = 64;

   // Per-allocation header added in front of the payload
   localparam int unsigned HEADER_BYTES = 4;

   // Field widths
   localparam int unsigned BUCKET_BYTES_W = 13;
   localparam int unsigned SIZE_W         = 12;
   localparam int unsigned FIELD_BIN_W    = 3;
   localparam int unsigned FIELD_SLOT_W   = 6;
   localparam int unsigned STATUS_W       = 3;
   localparam int unsigned KIND_W         = 2;
   localparam int unsigned REQ_DATA_W     = 24;
   localparam int unsigned RSP_DATA_W     = 16;
   localparam logic [BUCKET_BYTES_W-1:0] BUCKET_BYTES_RESET = 13'd64;

   // Divider: quotient bits retired per cycle and number of cycles
   localparam int unsigned DIV_STEPS  = 4;
   localparam int unsigned DIV_CYCLES = 4;
   localparam int unsigned DIV_W      = DIV_STEPS * DIV_CYCLES;

   // Depth of the command queue between front and back
   localparam int unsigned QUEUE_DEPTH = 2;

   // Request opcodes
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_ZERO      = 3'd1,
      ST_EMPTY     = 3'd2,
      ST_TOO_LARGE = 3'd3,
      ST_FREED     = 3'd4
   } status_type;

   // Command kinds handed from front to back
   typedef enum logic [KIND_W-1:0] {
      CMD_REPLY = 2'd0,
      CMD_ALLOC = 2'd1,
      CMD_FREE  = 2'd2
   } kind_type;

   // Front state machine
   typedef enum logic [1:0] {
      F_IDLE,
      F_DIV,
      F_PUSH
   } front_state_type;

   // Back state machine
   typedef enum logic [2:0] {
      B_CLEAR,
      B_IDLE,
      B_HEAD,
      B_LINK,
      B_REPLY
   } back_state_type;

endpackage

/* design/bfa_front.sv */
// ----------------------------------------------------------------------------
// bfa_front: request intake and classification
// Holds the bin size register, screens requests and runs the bin divider.
// ----------------------------------------------------------------------------
module bfa_front #(
   parameter int unsigned NUM_BINS      = bfa_pkg::NUM_BINS_DEFAULT,
   parameter int unsigned SLOTS_PER_BIN = bfa_pkg::SLOTS_PER_BIN_DEFAULT,
   parameter int unsigned CMD_W         = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   // Bin size register write
   input  logic                               csr_wvalid,
   output logic                               csr_wready,
   input  logic [bfa_pkg::BUCKET_BYTES_W-1:0] csr_wdata,
   // Requests
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // req_tdata, low bit up: request_size[11:0], free_bin[14:12], free_slot[20:15]
   input  logic [bfa_pkg::REQ_DATA_W-1:0]     req_tdata,
   // req_tuser: opcode[0]
   input  logic                               req_tuser,
   // Back is done clearing the pool
   input  logic                               init_done,
   // Command queue push side
   output logic                               push_valid,
   input  logic                               push_ready,
   output logic [CMD_W-1:0]                   push_data
);
   import bfa_pkg::*;

   localparam int unsigned BIN_W    = $clog2(NUM_BINS);
   localparam int unsigned SLOT_W   = $clog2(SLOTS_PER_BIN);
   localparam int unsigned DIV_CW   = $clog2(DIV_CYCLES);

   typedef struct packed {
      kind_type          kind;
      status_type        status;
      logic [BIN_W-1:0]  bin;
      logic [SLOT_W-1:0] slot;
   } cmd_type;

   front_state_type           state_ff, state_in;
   cmd_type                   cmd_ff, cmd_in;
   logic [BUCKET_BYTES_W-1:0] bucket_bytes_ff, bucket_bytes_in;
   logic [DIV_W-1:0]          div_q_ff, div_q_in;
   logic [BUCKET_BYTES_W-1:0] div_rem_ff, div_rem_in;
   logic [DIV_CW-1:0]         div_cnt_ff, div_cnt_in;

   logic [BUCKET_BYTES_W-1:0] divisor;
   logic [DIV_W-1:0]          step_q;
   logic [BUCKET_BYTES_W-1:0] step_rem;
   logic                      req_accept;
   logic                      div_last;
   logic [SIZE_W-1:0]         req_size;
   logic [FIELD_BIN_W-1:0]    req_bin;
   logic [FIELD_SLOT_W-1:0]   req_slot;

   // Unpack request fields
   assign req_size   = req_tdata[11:0];
   assign req_bin    = req_tdata[14:12];
   assign req_slot   = req_tdata[20:15];
   assign req_accept = req_tvalid && req_tready;
   assign div_last   = (div_cnt_ff == DIV_CW'(DIV_CYCLES - 1));
   assign push_data  = cmd_ff;

   // Treat a zero bin size as one
   assign divisor = (bucket_bytes_ff == '0) ? BUCKET_BYTES_W'(1) : bucket_bytes_ff;

   // Retire several restoring-division quotient bits
   always_comb begin : div_step
      logic [BUCKET_BYTES_W-1:0] rem;
      logic [DIV_W-1:0]          quo;
      logic [BUCKET_BYTES_W:0]   trial;
      rem = div_rem_ff;
      quo = div_q_ff;
      for (int i = 0; i < int'(DIV_STEPS); i++) begin
         trial = {rem, quo[DIV_W-1]};
         quo   = {quo[DIV_W-2:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            trial  = trial - {1'b0, divisor};
            quo[0] = 1'b1;
         end
         rem = trial[BUCKET_BYTES_W-1:0];
      end
      step_q   = quo;
      step_rem = rem;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         F_IDLE: begin
            if (req_accept) begin
               if (req_tuser == OP_ALLOC && req_size != '0) state_in = F_DIV;
               else state_in = F_PUSH;
            end
         end
         F_DIV: begin
            if (div_last) state_in = F_PUSH;
         end
         F_PUSH: begin
            if (push_ready) state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   // Handshake outputs
   always_comb begin
      req_tready = 1'b0;
      push_valid = 1'b0;
      case (state_ff)
         F_IDLE:  req_tready = init_done;
         F_PUSH:  push_valid = 1'b1;
         F_DIV:   req_tready = 1'b0;
         default: req_tready = 1'b0;
      endcase
   end

   assign csr_wready = 1'b1;

   // Take bin size writes, classify requests, and load and step the divider
   always_comb begin
      cmd_in          = cmd_ff;
      div_q_in        = div_q_ff;
      div_rem_in      = div_rem_ff;
      div_cnt_in      = div_cnt_ff;
      bucket_bytes_in = bucket_bytes_ff;
      if (csr_wvalid && csr_wready) bucket_bytes_in = csr_wdata;
      if (state_ff == F_IDLE && req_accept) begin
         cmd_in.bin  = '0;
         cmd_in.slot = '0;
         if (req_tuser == OP_FREE) begin
            cmd_in.status = ST_FREED;
            if (32'(req_bin) < NUM_BINS && 32'(req_slot) < SLOTS_PER_BIN) begin
               cmd_in.kind = CMD_FREE;
               cmd_in.bin  = BIN_W'(req_bin);
               cmd_in.slot = SLOT_W'(req_slot);
            end else begin
               cmd_in.kind = CMD_REPLY;
            end
         end else if (req_size == '0) begin
            cmd_in.kind   = CMD_REPLY;
            cmd_in.status = ST_ZERO;
         end else begin
            // ceil((size + header) / bin size) = floor((size + header - 1) / bin size) + 1
            div_q_in   = DIV_W'(req_size) + DIV_W'(HEADER_BYTES - 1);
            div_rem_in = '0;
            div_cnt_in = '0;
         end
      end else if (state_ff == F_DIV) begin
         div_q_in   = step_q;
         div_rem_in = step_rem;
         div_cnt_in = div_cnt_ff + DIV_CW'(1);
         if (div_last) begin
            if (step_q >= DIV_W'(NUM_BINS - 1)) begin
               cmd_in.kind   = CMD_REPLY;
               cmd_in.status = ST_TOO_LARGE;
            end else begin
               cmd_in.kind   = CMD_ALLOC;
               cmd_in.status = ST_OK;
               cmd_in.bin    = BIN_W'(step_q + DIV_W'(1));
            end
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= F_IDLE;
         bucket_bytes_ff <= BUCKET_BYTES_RESET;
      end else begin
         state_ff        <= state_in;
         bucket_bytes_ff <= bucket_bytes_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      div_q_ff   <= div_q_in;
      div_rem_ff <= div_rem_in;
      div_cnt_ff <= div_cnt_in;
   end

endmodule

/* design/bfa_cmd_queue.sv */
// ----------------------------------------------------------------------------
// bfa_cmd_queue: short command queue between front and back
// Small register FIFO so that intake and execution stall independently.
// ----------------------------------------------------------------------------
module bfa_cmd_queue #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = bfa_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) count_in = count_ff + CNT_W'(1);
      else if (!do_push && do_pop) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed items
   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

/* design/bfa_back.sv */
// ----------------------------------------------------------------------------
// bfa_back: free-list execution
// Owns the head and link memories, clears them after reset, pops and pushes
// slots and drives the registered response channel.
// ----------------------------------------------------------------------------
module bfa_back #(
   parameter int unsigned NUM_BINS      = bfa_pkg::NUM_BINS_DEFAULT,
   parameter int unsigned SLOTS_PER_BIN = bfa_pkg::SLOTS_PER_BIN_DEFAULT,
   parameter int unsigned CMD_W         = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   // Command queue pop side
   input  logic                           pop_valid,
   output logic                           pop_ready,
   input  logic [CMD_W-1:0]               pop_data,
   // Pool clearing finished
   output logic                           init_done,
   // Responses
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // rsp_tdata, low bit up: bin[2:0], slot[8:3]
   output logic [bfa_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // rsp_tuser: status[2:0]
   output logic [bfa_pkg::STATUS_W-1:0]   rsp_tuser
);
   import bfa_pkg::*;

   localparam int unsigned BIN_W      = $clog2(NUM_BINS);
   localparam int unsigned SLOT_W     = $clog2(SLOTS_PER_BIN);
   localparam int unsigned HEAD_W     = $clog2(SLOTS_PER_BIN + 1);
   localparam int unsigned LINK_DEPTH = NUM_BINS * SLOTS_PER_BIN;
   localparam int unsigned LINK_AW    = $clog2(LINK_DEPTH);

   typedef struct packed {
      kind_type          kind;
      status_type        status;
      logic [BIN_W-1:0]  bin;
      logic [SLOT_W-1:0] slot;
   } cmd_type;

   // Memories
   logic [HEAD_W-1:0] head_mem [NUM_BINS];
   logic [HEAD_W-1:0] link_mem [LINK_DEPTH];

   back_state_type      state_ff, state_in;
   cmd_type             cmd_ff;
   cmd_type             pop_cmd;
   logic [HEAD_W-1:0]   head_rd_ff;
   logic [HEAD_W-1:0]   link_rd_ff;
   logic [LINK_AW-1:0]  clr_addr_ff;
   logic [SLOT_W-1:0]   clr_slot_ff;
   logic [BIN_W-1:0]    clr_bin_ff;
   status_type          res_status_ff;
   logic [FIELD_BIN_W-1:0]  res_bin_ff;
   logic [FIELD_SLOT_W-1:0] res_slot_ff;
   logic                rsp_tvalid_ff;
   status_type          rsp_status_ff;
   logic [FIELD_BIN_W-1:0]  rsp_bin_ff;
   logic [FIELD_SLOT_W-1:0] rsp_slot_ff;

   logic                head_we;
   logic [BIN_W-1:0]    head_waddr, head_raddr;
   logic [HEAD_W-1:0]   head_wdata;
   logic                link_we;
   logic [LINK_AW-1:0]  link_waddr, link_raddr;
   logic [HEAD_W-1:0]   link_wdata;
   logic                clr_last;
   logic                head_empty;
   logic                out_free;

   function automatic logic [LINK_AW-1:0] link_addr(input logic [BIN_W-1:0] b,
                                                   input logic [SLOT_W-1:0] s);
      link_addr = LINK_AW'(b) * LINK_AW'(SLOTS_PER_BIN) + LINK_AW'(s);
   endfunction

   assign pop_cmd    = pop_data;
   assign clr_last   = (clr_addr_ff == LINK_AW'(LINK_DEPTH - 1));
   assign head_empty = (head_rd_ff >= HEAD_W'(SLOTS_PER_BIN));
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_CLEAR: begin
            if (clr_last) state_in = B_IDLE;
         end
         B_IDLE: begin
            if (pop_valid) begin
               if (pop_cmd.kind == CMD_REPLY) state_in = B_REPLY;
               else state_in = B_HEAD;
            end
         end
         B_HEAD: begin
            if (cmd_ff.kind == CMD_ALLOC && !head_empty) state_in = B_LINK;
            else state_in = B_REPLY;
         end
         B_LINK:  state_in = B_REPLY;
         B_REPLY: begin
            if (out_free) state_in = B_IDLE;
         end
         default: state_in = B_IDLE;
      endcase
   end

   // Memory ports and queue handshake
   always_comb begin
      pop_ready  = 1'b0;
      init_done  = 1'b1;
      head_raddr = pop_cmd.bin;
      link_raddr = link_addr(cmd_ff.bin, head_rd_ff[SLOT_W-1:0]);
      head_we    = 1'b0;
      head_waddr = cmd_ff.bin;
      head_wdata = link_rd_ff;
      link_we    = 1'b0;
      link_waddr = link_addr(cmd_ff.bin, cmd_ff.slot);
      link_wdata = head_rd_ff;
      case (state_ff)
         B_CLEAR: begin
            init_done  = 1'b0;
            head_we    = (clr_slot_ff == '0);
            head_waddr = clr_bin_ff;
            head_wdata = '0;
            link_we    = 1'b1;
            link_waddr = clr_addr_ff;
            link_wdata = HEAD_W'(clr_slot_ff) + HEAD_W'(1);
         end
         B_IDLE: pop_ready = 1'b1;
         B_HEAD: begin
            // Push a freed slot onto its bin's list
            if (cmd_ff.kind == CMD_FREE) begin
               head_we    = 1'b1;
               head_wdata = HEAD_W'(cmd_ff.slot);
               link_we    = 1'b1;
            end
         end
         B_LINK: head_we = 1'b1;
         B_REPLY: pop_ready = 1'b0;
         default: pop_ready = 1'b0;
      endcase
   end

   // Head memory
   always_ff @(posedge clock) begin
      if (head_we) head_mem[head_waddr] <= head_wdata;
      head_rd_ff <= head_mem[head_raddr];
   end

   // Link memory
   always_ff @(posedge clock) begin
      if (link_we) link_mem[link_waddr] <= link_wdata;
      link_rd_ff <= link_mem[link_raddr];
   end

   // Control registers: state, clearing sweep, output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= B_CLEAR;
         clr_addr_ff   <= '0;
         clr_slot_ff   <= '0;
         clr_bin_ff    <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == B_CLEAR) begin
            clr_addr_ff <= clr_addr_ff + LINK_AW'(1);
            if (clr_slot_ff == SLOT_W'(SLOTS_PER_BIN - 1)) begin
               clr_slot_ff <= '0;
               clr_bin_ff  <= clr_bin_ff + BIN_W'(1);
            end else begin
               clr_slot_ff <= clr_slot_ff + SLOT_W'(1);
            end
         end
         if (state_ff == B_REPLY && out_free) rsp_tvalid_ff <= 1'b1;
         else if (rsp_tready) rsp_tvalid_ff <= 1'b0;
      end
   end

   // Capture command and build the result
   always_ff @(posedge clock) begin
      case (state_ff)
         B_IDLE: begin
            cmd_ff        <= pop_cmd;
            res_status_ff <= pop_cmd.status;
            res_bin_ff    <= '0;
            res_slot_ff   <= '0;
         end
         B_HEAD: begin
            if (cmd_ff.kind == CMD_ALLOC) begin
               if (head_empty) res_status_ff <= ST_EMPTY;
               res_slot_ff <= FIELD_SLOT_W'(head_rd_ff[SLOT_W-1:0]);
            end
         end
         B_LINK: begin
            res_status_ff <= ST_OK;
            res_bin_ff    <= FIELD_BIN_W'(cmd_ff.bin);
         end
         B_REPLY: begin
            if (out_free) begin
               rsp_status_ff <= res_status_ff;
               rsp_bin_ff    <= (res_status_ff == ST_OK) ? res_bin_ff : '0;
               rsp_slot_ff   <= (res_status_ff == ST_OK) ? res_slot_ff : '0;
            end
         end
         default: res_bin_ff <= res_bin_ff;
      endcase
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {(RSP_DATA_W - FIELD_SLOT_W - FIELD_BIN_W)'(0), rsp_slot_ff, rsp_bin_ff};

endmodule

/* design/binned_free_list_allocator_unit.sv */
// ----------------------------------------------------------------------------
// binned_free_list_allocator_unit: size-binned pool allocator
// Pops and pushes slot handles on per-bin free lists.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one request per item: allocate (req_tuser = 0) with a byte
//   size, or free (req_tuser = 1) with a bin and slot handle. rsp_* returns
//   one item per request: status in rsp_tuser, bin and slot in rsp_tdata.
//   csr_w* writes the bin size; write it only while no request is in flight.
// Timing:
//   An allocate passes the front (accept, the divider retiring four
//   quotient bits at a time, queue push), then the back (head read, link
//   read, head update, reply). A free or an early error skips the divider
//   in the front and the link step in the back. The front takes a new
//   request only once the last is pushed, so the divider bounds throughput.
// Reset:
//   After reset the back sweeps the link memory once, one entry a cycle,
//   over NUM_BINS * SLOTS_PER_BIN entries (512 by default); req_tready
//   stays low during the sweep. Bin size returns to 64.
// Stall:
//   A stalled response is held in its output register; the command queue
//   lets the front accept and classify further requests meanwhile.
// ----------------------------------------------------------------------------
module binned_free_list_allocator_unit #(
   parameter int unsigned NUM_BINS      = bfa_pkg::NUM_BINS_DEFAULT,
   parameter int unsigned SLOTS_PER_BIN = bfa_pkg::SLOTS_PER_BIN_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wvalid,
   output logic                               csr_wready,
   input  logic [bfa_pkg::BUCKET_BYTES_W-1:0] csr_wdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // req_tdata, low bit up: request_size[11:0], free_bin[14:12], free_slot[20:15]
   input  logic [bfa_pkg::REQ_DATA_W-1:0]     req_tdata,
   // req_tuser: opcode[0]
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // rsp_tdata, low bit up: bin[2:0], slot[8:3]
   output logic [bfa_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // rsp_tuser: status[2:0]
   output logic [bfa_pkg::STATUS_W-1:0]       rsp_tuser
);
   import bfa_pkg::*;

   localparam int unsigned BIN_W  = $clog2(NUM_BINS);
   localparam int unsigned SLOT_W = $clog2(SLOTS_PER_BIN);
   localparam int unsigned CMD_W  = KIND_W + STATUS_W + BIN_W + SLOT_W;

   logic             push_valid, push_ready;
   logic [CMD_W-1:0] push_data;
   logic             pop_valid, pop_ready;
   logic [CMD_W-1:0] pop_data;
   logic             init_done;

   bfa_front #(
      .NUM_BINS      (NUM_BINS),
      .SLOTS_PER_BIN (SLOTS_PER_BIN),
      .CMD_W         (CMD_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_wvalid (csr_wvalid),
      .csr_wready (csr_wready),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .init_done  (init_done),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   bfa_cmd_queue #(
      .WIDTH (CMD_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   bfa_back #(
      .NUM_BINS      (NUM_BINS),
      .SLOTS_PER_BIN (SLOTS_PER_BIN),
      .CMD_W         (CMD_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .init_done  (init_done),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

/* design/bfa_checker.sv */
// ----------------------------------------------------------------------------
// bfa_checker: port-level checks of the allocator
// Watches reset behavior, response hold and result encoding.
// ----------------------------------------------------------------------------
module bfa_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tready,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [bfa_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic [bfa_pkg::STATUS_W-1:0]   rsp_tuser
);
   import bfa_pkg::*;

   // Hold a stalled response item
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // Drop the handle on every status other than allocated
   a_handle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_OK |-> rsp_tdata == '0)
      else $error("handle not zero on a failed or free response");

   // Report only defined status codes
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser <= ST_FREED)
      else $error("undefined response status");

   // Block intake and output in the cycle after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready)
      else $error("activity right after reset");

endmodule

bind binned_free_list_allocator_unit bfa_checker u_checker (.*);
